// File: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// shared codes and types for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

endpackage

// File: src/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// accepts beats, forms products, sums and divisor, writes a short queue
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int DW = 16,
  parameter int PW = 2 * DW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           op_i,
  input  logic signed [DW-1:0] ar_i,
  input  logic signed [DW-1:0] ai_i,
  input  logic signed [DW-1:0] br_i,
  input  logic signed [DW-1:0] bi_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic [2:0]           q_op_o,
  output logic signed [PW-1:0] q_x_o,
  output logic signed [PW-1:0] q_y_o,
  output logic [PW-1:0]        q_den_o
);

  localparam int Depth = 4;

  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [PW-1:0]        d_q;
  logic [2:0]           sop_q;
  logic                 sv_q;
  logic [2:0]           mop [Depth];
  logic signed [PW-1:0] mx [Depth];
  logic signed [PW-1:0] my [Depth];
  logic [PW-1:0]        md [Depth];
  logic [1:0]           wp_q, rp_q;
  logic [2:0]           cnt_q;
  logic signed [PW-1:0] x_c, y_c;
  logic                 push, pop;

  // credit for the product stage too
  assign in_ready_o = (cnt_q + {2'b0, sv_q}) < 3'(Depth);
  assign push = sv_q;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sop_q <= op_i;
      unique case (op_i)
        OP_ADD, OP_SUB, OP_CONJ: begin
          p1_q <= PW'(ar_i);
          p2_q <= PW'(br_i);
          p3_q <= PW'(ai_i);
          p4_q <= PW'(bi_i);
        end
        default: begin
          p1_q <= PW'(ar_i * br_i);
          p2_q <= PW'(ai_i * bi_i);
          p3_q <= PW'(ai_i * br_i);
          p4_q <= PW'(ar_i * bi_i);
        end
      endcase
      d_q <= PW'(br_i * br_i) + PW'(bi_i * bi_i);
    end
  end

  always_comb begin
    x_c = '0;
    y_c = '0;
    unique case (sop_q)
      OP_ADD:  begin x_c = p1_q + p2_q; y_c = p3_q + p4_q; end
      OP_SUB:  begin x_c = p1_q - p2_q; y_c = p3_q - p4_q; end
      OP_MUL:  begin x_c = p1_q - p2_q; y_c = p3_q + p4_q; end
      OP_DIV:  begin x_c = p1_q + p2_q; y_c = p3_q - p4_q; end
      OP_CONJ: begin x_c = p1_q; y_c = -p3_q; end
      default: begin x_c = '0; y_c = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mop[wp_q] <= sop_q;
      mx[wp_q]  <= x_c;
      my[wp_q]  <= y_c;
      md[wp_q]  <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
    end
  end

  assign q_valid_o = cnt_q != '0;
  assign q_op_o    = mop[rp_q];
  assign q_x_o     = mx[rp_q];
  assign q_y_o     = my[rp_q];
  assign q_den_o   = md[rp_q];

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(Depth)) else $error("queue overflow");
  a_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("pop of empty queue");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> sv_q) else $error("lost beat");
`endif

endmodule

// File: src/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// shift, pipelined restoring divide, saturation and output register
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int DW = 16,
  parameter int FB = 8,
  parameter int PW = 2 * DW + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic [2:0]           q_op_i,
  input  logic signed [PW-1:0] q_x_i,
  input  logic signed [PW-1:0] q_y_i,
  input  logic [PW-1:0]        q_den_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DW-1:0]        rr_o,
  output logic [DW-1:0]        ri_o,
  output logic [1:0]           st_o
);

  // numerator magnitude is PW bits, shifted by FB; quotient bits
  localparam int NW = PW + FB;
  localparam int NS = NW;

  typedef struct packed {
    logic [2:0]    op;
    logic          nx, ny;
    logic [NW-1:0] nmx, nmy;
    logic [NW-1:0] qx, qy;
    logic [NW-1:0] rx, ry;
    logic [PW-1:0] den;
  } stg_t;

  stg_t s_q [NS+1];
  logic v_q [NS+1];
  logic adv;
  logic [PW-1:0] ax, ay;

  assign adv = !out_valid_o || out_ready_i;
  assign q_ready_o = adv;
  assign ax = q_x_i[PW-1] ? -q_x_i : q_x_i;
  assign ay = q_y_i[PW-1] ? -q_y_i : q_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= q_valid_i;
      for (int i = 1; i <= NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q[0].op  <= q_op_i;
      s_q[0].nx  <= q_x_i[PW-1];
      s_q[0].ny  <= q_y_i[PW-1];
      s_q[0].nmx <= NW'(ax) << FB;
      s_q[0].nmy <= NW'(ay) << FB;
      s_q[0].qx  <= '0;
      s_q[0].qy  <= '0;
      s_q[0].rx  <= '0;
      s_q[0].ry  <= '0;
      s_q[0].den <= q_den_i;
      for (int i = 1; i <= NS; i++) begin
        stg_t nxt;
        logic [NW:0] tx, ty;
        nxt = s_q[i-1];
        tx = {s_q[i-1].rx, s_q[i-1].nmx[NW-i]};
        ty = {s_q[i-1].ry, s_q[i-1].nmy[NW-i]};
        if (tx >= (NW+1)'(s_q[i-1].den)) begin
          nxt.rx = NW'(tx - (NW+1)'(s_q[i-1].den));
          nxt.qx = {s_q[i-1].qx[NW-2:0], 1'b1};
        end else begin
          nxt.rx = NW'(tx);
          nxt.qx = {s_q[i-1].qx[NW-2:0], 1'b0};
        end
        if (ty >= (NW+1)'(s_q[i-1].den)) begin
          nxt.ry = NW'(ty - (NW+1)'(s_q[i-1].den));
          nxt.qy = {s_q[i-1].qy[NW-2:0], 1'b1};
        end else begin
          nxt.ry = NW'(ty);
          nxt.qy = {s_q[i-1].qy[NW-2:0], 1'b0};
        end
        s_q[i] <= nxt;
      end
    end
  end

  stg_t f;
  logic [NW-1:0] mx, my;
  logic [DW-1:0] rr_c, ri_c;
  logic sx, sy, zx, zy;
  logic [1:0] st_c;
  localparam logic [NW-1:0] MaxM = NW'((64'd1 << (DW-1)) - 1);
  localparam logic [NW-1:0] MinM = NW'(64'd1 << (DW-1));
  localparam logic [NW-1:0] RndM = NW'(((64'd1 << FB) - 1) << FB);

  function automatic logic [DW:0] sat_f(input logic neg, input logic [NW-1:0] m);
    logic [DW:0] r;
    if (!neg) begin
      r = (m > MaxM) ? {1'b1, MaxM[DW-1:0]} : {1'b0, m[DW-1:0]};
    end else begin
      r = (m > MinM) ? {1'b1, MinM[DW-1:0]} : {1'b0, DW'(-m[DW-1:0])};
    end
    return r;
  endfunction

  always_comb begin
    logic [DW:0] ox, oy;
    f = s_q[NS];
    mx = f.nmx >> FB;
    my = f.nmy >> FB;
    sx = f.nx;
    sy = f.ny;
    unique case (f.op)
      OP_MUL: begin
        if (f.nx) mx = (f.nmx + RndM) >> (2 * FB);
        else mx = f.nmx >> (2 * FB);
        if (f.ny) my = (f.nmy + RndM) >> (2 * FB);
        else my = f.nmy >> (2 * FB);
      end
      OP_DIV: begin
        mx = f.qx;
        my = f.qy;
      end
      default: begin
      end
    endcase
    zx = mx == '0;
    zy = my == '0;
    ox = sat_f(sx && !zx, mx);
    oy = sat_f(sy && !zy, my);
    rr_c = ox[DW-1:0];
    ri_c = oy[DW-1:0];
    st_c = (ox[DW] || oy[DW]) ? ST_SAT : ST_OK;
    if (f.op == OP_DIV && f.den == '0) begin
      rr_c = '0;
      ri_c = '0;
      st_c = ST_DIV0;
    end
    if (f.op > OP_CONJ) begin
      rr_c = '0;
      ri_c = '0;
      st_c = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_o <= rr_c;
      ri_o <= ri_c;
      st_o <= st_c;
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(rr_o))
    else $error("result changed under stall");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_o != 2'd3) else $error("bad status");
  a_d0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && st_o == ST_DIV0) |-> rr_o == '0 && ri_o == '0)
    else $error("divide by zero gave data");
`endif

endmodule

// File: src/complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// complex add, subtract, multiply, divide and conjugate on fixed point
// ----------------------------------------------------------------------------
// One beat in and one beat out per cycle while m_axis_tready is not holding
// the output back; every beat passes through the pipelined restoring divider,
// one quotient bit per stage.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], a_real, a_imag, b_real, b_imag
  input  logic [((3 + 4 * DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_real, result_imag, status[1:0]
  output logic [((2 * DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DW + 2;
  localparam int OW = ((2 * DW + 2 + 7) / 8) * 8;

  logic                 qv, qr;
  logic [2:0]           qop;
  logic signed [PW-1:0] qx, qy;
  logic [PW-1:0]        qd;
  logic [DW-1:0]        rr, ri;
  logic [1:0]           st;

  cau_front #(.DW(DW), .PW(PW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tdata[2:0]),
    .ar_i(s_axis_tdata[3 +: DW]),
    .ai_i(s_axis_tdata[3 + DW +: DW]),
    .br_i(s_axis_tdata[3 + 2 * DW +: DW]),
    .bi_i(s_axis_tdata[3 + 3 * DW +: DW]),
    .q_valid_o(qv), .q_ready_i(qr), .q_op_o(qop),
    .q_x_o(qx), .q_y_o(qy), .q_den_o(qd)
  );

  cau_back #(.DW(DW), .FB(FRAC_BITS), .PW(PW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_op_i(qop),
    .q_x_i(qx), .q_y_i(qy), .q_den_i(qd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .rr_o(rr), .ri_o(ri), .st_o(st)
  );

  assign m_axis_tdata = OW'({st, ri, rr});

endmodule

// File: tb/sv/complex_arith_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// self-checking bench for the complex arithmetic unit: directed corner beats
// per operation, then random beats with random idling on both sides and then
// without, each output beat compared with an in-bench fixed-point prediction
// ----------------------------------------------------------------------------
module complex_arith_unit_test import cau_pkg::*; ();

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int IN_W = ((3 + 4 * DW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * DW + 2 + 7) / 8) * 8;
  localparam longint MAXV = 32767;
  localparam longint MINV = -32768;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic signed [DW-1:0] res_imag;
    logic signed [DW-1:0] res_real;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  result_t expected_results[$];
  int errors = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;

  complex_arith_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint sat_val(longint v, ref bit sat);
    if (v > MAXV) begin
      sat = 1'b1;
      return MAXV;
    end
    if (v < MINV) begin
      sat = 1'b1;
      return MINV;
    end
    return v;
  endfunction

  // quotient of (num << FB) / den truncated toward zero
  function automatic longint div_trunc(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic result_t predict_complex(logic [2:0] op, longint ar, longint ai,
                                              longint br, longint bi);
    result_t r;
    bit sat;
    longint rr;
    longint ri;
    longint den;
    sat = 1'b0;
    rr = 0;
    ri = 0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        rr = sat_val(ar + br, sat);
        ri = sat_val(ai + bi, sat);
      end
      OP_SUB: begin
        rr = sat_val(ar - br, sat);
        ri = sat_val(ai - bi, sat);
      end
      OP_MUL: begin
        rr = sat_val((ar * br - ai * bi) >>> FB, sat);
        ri = sat_val((ai * br + ar * bi) >>> FB, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          rr = sat_val(div_trunc(ar * br + ai * bi, den), sat);
          ri = sat_val(div_trunc(ai * br - ar * bi, den), sat);
        end
      end
      OP_CONJ: begin
        rr = ar;
        ri = sat_val(-ai, sat);
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    r.res_real = rr[DW-1:0];
    r.res_imag = ri[DW-1:0];
    return r;
  endfunction

  task automatic send_beat(logic [2:0] op, logic [DW-1:0] ar, logic [DW-1:0] ai,
                           logic [DW-1:0] br, logic [DW-1:0] bi);
    int gap;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= IN_W'({bi, br, ai, ar, op});
    s_axis_tvalid <= 1'b1;
    expected_results.push_back(predict_complex(op, $signed(ar), $signed(ai),
                                               $signed(br), $signed(bi)));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t got;
      result_t exp_r;
      got = m_axis_tdata[2*DW+1:0];
      if (expected_results.size() == 0) begin
        $display("%0t unexpected beat actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.res_real !== exp_r.res_real) begin
          $display("%0t result_real expected %0d actual %0d", $time,
                   exp_r.res_real, got.res_real);
          errors++;
        end
        if (got.res_imag !== exp_r.res_imag) begin
          $display("%0t result_imag expected %0d actual %0d", $time,
                   exp_r.res_imag, got.res_imag);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $display("%0t status expected %0d actual %0d", $time,
                   exp_r.status, got.status);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_add_sub();
    logic [DW-1:0] mx = 16'h7fff;
    logic [DW-1:0] mn = 16'h8000;
    send_beat(OP_ADD, mx, mn, 16'h0001, 16'hffff);
    send_beat(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
    send_beat(OP_SUB, mn, mx, 16'h0001, 16'hffff);
    send_beat(OP_SUB, mx, mn, mn, mx);
    send_beat(OP_ADD, mn, mn, mn, mn);
    end_burst();
  endtask

  task automatic test_mul();
    send_beat(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_beat(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_beat(OP_MUL, 16'h0180, 16'hff40, 16'h0200, 16'h0030);
    end_burst();
  endtask

  task automatic test_div();
    send_beat(OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
    send_beat(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_beat(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(OP_DIV, 16'hfe00, 16'h0300, 16'h0000, 16'hff00);
    send_beat(OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h7fff);
    send_beat(OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
    end_burst();
  endtask

  task automatic test_conj_unused();
    send_beat(OP_CONJ, 16'h8000, 16'h8000, 16'h1111, 16'h2222);
    send_beat(OP_CONJ, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    send_beat(OP_CONJ, 16'h0005, 16'hfffb, 16'hffff, 16'hffff);
    for (logic [3:0] op = {1'b0, OP_UNUSED_LO}; op <= {1'b0, OP_UNUSED_HI}; op++)
      send_beat(op[2:0], 16'h4321, 16'h8765, 16'h0fed, 16'hcba9);
    end_burst();
  endtask

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h7fff - 16'($urandom_range(0, 3));
      1: return 16'h8000 + 16'($urandom_range(0, 3));
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_random(int count);
    logic [2:0] op;
    logic [DW-1:0] br;
    logic [DW-1:0] bi;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      br = rand_operand();
      bi = rand_operand();
      if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_beat(op, rand_operand(), rand_operand(), br, bi);
      if (i == count / 2) begin
        end_burst();
        wait_drained();
      end
    end
    end_burst();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_sub();
    test_mul();
    test_div();
    test_conj_unused();
    test_random(900);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(200);
    wait_drained();
    repeat (2 * DW + FB + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
